// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file twt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/twt_pkg.sv =====
`default_nettype none

package twt_pkg;

	localparam int TIMER_ENTRIES_DEF = 16;
	localparam int MAX_SLOTS_DEF     = 64;
	localparam int WHEEL_LIMIT       = 64;
	localparam int RESULT_LIMIT      = 16;
	localparam int PTR_W             = 6;
	localparam int CNT_W             = 7;
	localparam int ID_W              = 16;
	localparam int ROUNDS_W          = 16;
	localparam int NCNT_W            = $clog2(RESULT_LIMIT + 1);
	localparam int MOD_STEPS         = CNT_W;
	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(WHEEL_LIMIT);

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_DONE      = 3'd0,
		STAT_EXPIRED   = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_BAD_SLOT  = 3'd3,
		STAT_ID_IN_USE = 3'd4,
		STAT_NOT_FOUND = 3'd5
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRAP,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [ID_W-1:0]     timer_id;
		logic [PTR_W-1:0]    wheel_slot;
		logic [ROUNDS_W-1:0] rounds;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] expired_id;
		logic            last;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [PTR_W-1:0]    slot;
		logic [ROUNDS_W-1:0] rounds;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_adv;
		logic wrap_step;
		logic reply;
	} ctl_t;

	typedef struct packed {
		logic is_tick;
		logic scan_stall;
		logic scan_done;
		logic wrap_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/twt_ram.sv =====
`default_nettype none

module twt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/twt_ctrl.sv =====
`default_nettype none

module twt_ctrl import twt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output      logic in_ready,
	input  wire sts_t sts,
	output      ctl_t ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan_adv = !sts.scan_stall;
				if (sts.scan_done) begin
					state_d = sts.is_tick ? ST_WRAP : ST_REPLY;
				end
			end
			ST_WRAP: begin
				ctl.wrap_step = 1'b1;
				if (sts.wrap_done) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (sts.out_free) begin
					ctl.reply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/twt_datapath.sv =====
`default_nettype none

module twt_datapath import twt_pkg::*; #(
	parameter int TIMER_ENTRIES = TIMER_ENTRIES_DEF,
	parameter int MAX_SLOTS     = MAX_SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	input  wire req_t             in_req,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      rsp_t             out_rsp,
	input  wire ctl_t             ctl,
	output      sts_t             sts
);

	localparam int IW = $clog2(TIMER_ENTRIES);
	localparam logic [IW:0] SCAN_END = (IW + 1)'(TIMER_ENTRIES);
	localparam logic [CNT_W-1:0] SLOT_CAP =
		CNT_W'((MAX_SLOTS < WHEEL_LIMIT) ? MAX_SLOTS : WHEEL_LIMIT);

	logic [CNT_W-1:0]         slot_count_q;
	logic [TIMER_ENTRIES-1:0] valid_q;
	logic [PTR_W-1:0]         ptr_q;
	req_t                     item_q;
	logic [IW:0]              rd_idx_q;
	logic                     proc_v_s1;
	logic [IW-1:0]            proc_idx_s1;
	logic                     pend_v_q;
	logic [ID_W-1:0]          pend_id_q;
	logic [NCNT_W-1:0]        n_q;
	logic                     match_q;
	logic                     free_v_q;
	logic [IW-1:0]            free_idx_q;
	logic [CNT_W-1:0]         rem_q;
	logic [2:0]               bit_q;
	logic                     out_v_q;
	rsp_t                     out_q;

	entry_t           ent;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	entry_t           ram_wdata;
	logic             rd_more;
	logic [CNT_W-1:0] count;
	logic             is_tick;
	logic             hit;
	logic             id_hit;
	logic             emit;
	logic             dec;
	logic             del_hit;
	logic             add_free;
	logic             out_free;
	logic             scan_push;
	logic             bad_slot;
	logic             add_commit;
	rsp_t             final_rsp;
	logic [CNT_W-1:0] dividend;
	logic [CNT_W-1:0] trial;

	twt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TIMER_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.scan_adv && rd_more),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ent)
	);

	always_comb begin
		count = slot_count_q;
		if (slot_count_q == '0) begin
			count = CNT_W'(1);
		end else if (slot_count_q > SLOT_CAP) begin
			count = SLOT_CAP;
		end
	end

	assign rd_more  = (rd_idx_q != SCAN_END);
	assign is_tick  = (item_q.command == CMD_TICK);
	assign out_free = !out_v_q || out_ready;
	assign bad_slot = ({1'b0, item_q.wheel_slot} >= count);

	// Evaluate the entry whose data the RAM presents this cycle.
	assign hit      = proc_v_s1 && valid_q[proc_idx_s1] && (ent.slot == ptr_q);
	assign id_hit   = proc_v_s1 && valid_q[proc_idx_s1] && (ent.id == item_q.timer_id);
	assign emit     = is_tick && hit && (ent.rounds == '0) && (n_q < NCNT_W'(RESULT_LIMIT));
	assign dec      = is_tick && hit && (ent.rounds != '0);
	assign del_hit  = (item_q.command == CMD_DELETE) && id_hit && !match_q;
	assign add_free = (item_q.command == CMD_ADD) && proc_v_s1 && !valid_q[proc_idx_s1]
		&& !free_v_q;

	// A new expiry pushes the held one out as a non-final result.
	assign scan_push = ctl.scan_adv && emit && pend_v_q;

	always_comb begin
		final_rsp = '{status: STAT_DONE, expired_id: item_q.timer_id, last: 1'b1};
		case (item_q.command)
			CMD_TICK: begin
				if (pend_v_q) begin
					final_rsp.status     = STAT_EXPIRED;
					final_rsp.expired_id = pend_id_q;
				end
			end
			CMD_ADD: begin
				if (bad_slot) begin
					final_rsp.status = STAT_BAD_SLOT;
				end else if (match_q) begin
					final_rsp.status = STAT_ID_IN_USE;
				end else if (!free_v_q) begin
					final_rsp.status = STAT_FULL;
				end
			end
			CMD_DELETE: begin
				if (!match_q) begin
					final_rsp.status = STAT_NOT_FOUND;
				end
			end
			default: begin
				final_rsp.status = STAT_DONE;
			end
		endcase
	end

	assign add_commit = ctl.reply && (item_q.command == CMD_ADD) && !bad_slot && !match_q
		&& free_v_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = proc_idx_s1;
		ram_wdata = ent;
		if (ctl.scan_adv && dec) begin
			ram_we           = 1'b1;
			ram_wdata.rounds = ent.rounds - ROUNDS_W'(1);
		end else if (add_commit) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx_q;
			ram_wdata = '{id: item_q.timer_id, slot: item_q.wheel_slot, rounds: item_q.rounds};
		end
	end

	// One quotient bit per step of the pointer wrap.
	assign dividend = {1'b0, ptr_q} + CNT_W'(1);
	assign trial    = {rem_q[CNT_W-2:0], dividend[bit_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			valid_q      <= '0;
			ptr_q        <= '0;
			rd_idx_q     <= '0;
			proc_v_s1    <= 1'b0;
			pend_v_q     <= 1'b0;
			n_q          <= '0;
			match_q      <= 1'b0;
			free_v_q     <= 1'b0;
			bit_q        <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_data;
			end
			if (ctl.load) begin
				rd_idx_q  <= '0;
				proc_v_s1 <= 1'b0;
				pend_v_q  <= 1'b0;
				n_q       <= '0;
				match_q   <= 1'b0;
				free_v_q  <= 1'b0;
				bit_q     <= 3'(MOD_STEPS - 1);
			end
			if (ctl.scan_adv) begin
				proc_v_s1 <= rd_more;
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + (IW + 1)'(1);
				end
				if (emit) begin
					valid_q[proc_idx_s1] <= 1'b0;
					pend_v_q             <= 1'b1;
					n_q                  <= n_q + NCNT_W'(1);
				end
				if (del_hit) begin
					valid_q[proc_idx_s1] <= 1'b0;
				end
				if (id_hit) begin
					match_q <= 1'b1;
				end
				if (add_free) begin
					free_v_q <= 1'b1;
				end
			end
			if (ctl.wrap_step) begin
				bit_q <= bit_q - 3'd1;
			end
			if (add_commit) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (ctl.reply && is_tick) begin
				ptr_q <= rem_q[PTR_W-1:0];
			end
			if (scan_push || ctl.reply) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= in_req;
			rem_q  <= '0;
		end
		if (ctl.scan_adv) begin
			proc_idx_s1 <= rd_idx_q[IW-1:0];
			if (emit) begin
				pend_id_q <= ent.id;
			end
			if (add_free) begin
				free_idx_q <= proc_idx_s1;
			end
		end
		if (ctl.wrap_step) begin
			rem_q <= (trial >= count) ? (trial - count) : trial;
		end
		if (scan_push) begin
			out_q <= '{status: STAT_EXPIRED, expired_id: pend_id_q, last: 1'b0};
		end else if (ctl.reply) begin
			out_q <= final_rsp;
		end
	end

	always_comb begin
		sts.is_tick    = is_tick;
		sts.scan_stall = emit && pend_v_q && !out_free;
		sts.scan_done  = !rd_more && !proc_v_s1;
		sts.wrap_done  = (bit_q == '0);
		sts.out_free   = out_free;
	end

	assign out_valid = out_v_q;
	assign out_rsp   = out_q;

endmodule

`default_nettype wire

// ===== design/timing_wheel_timer_table.sv =====
// Hashed timing wheel over a table of TIMER_ENTRIES timers.
// Requests enter on in_valid/in_ready with in_req (tick, add, delete, no-op); results leave on
// out_valid/out_ready with out_rsp, one or more per request, the final one marked by last.
// cfg_we/cfg_data write the slot count; write it only while no request is in flight.
// Each request scans the whole table through a registered-read RAM, one entry per cycle
// unless a tick's scan stalls on a held result; a tick then runs the bit-serial pointer
// wrap before its final result. A new request is taken only after the final result of
// the last one has been loaded into the output register.
// in_ready is high only between requests. An output register holds the latest result,
// so the next request is taken while that result still waits.
// A tick with several expiries stalls its scan while a result is held in the output
// register and out_ready is low; nothing is dropped.
// Reset clears all timers, sets the wheel pointer to zero and the slot count to 64.
// The RAM holds timer fields only; validity lives in flip-flops, so no clearing pass runs.
`default_nettype none

module timing_wheel_timer_table import twt_pkg::*; #(
	parameter int TIMER_ENTRIES = TIMER_ENTRIES_DEF,
	parameter int MAX_SLOTS     = MAX_SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire req_t             in_req,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      rsp_t             out_rsp
);

	ctl_t ctl;
	sts_t sts;

	twt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	twt_datapath #(
		.TIMER_ENTRIES (TIMER_ENTRIES),
		.MAX_SLOTS     (MAX_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== design/twt_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module twt_checker import twt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_rsp
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rsp), "result dropped or changed while stalled")
	`ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while another is in work")
	`ASSERT_NOW(a_status_range, out_valid, out_rsp.status <= STAT_NOT_FOUND, "status code out of range")
	`ASSERT_NOW(a_single_last, out_valid && out_rsp.status != STAT_EXPIRED, out_rsp.last, "non-expiry result without last")

endmodule

bind timing_wheel_timer_table twt_checker u_twt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_rsp   (out_rsp)
);

`default_nettype wire
